// ===== rtl/pfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

    // Position counters hold one value past the last index as the end sentinel.
    localparam int BUS_POS_W = 9;
    localparam int DEV_POS_W = 6;
    localparam int FN_POS_W  = 4;

    localparam logic [15:0] NO_VENDOR     = 16'hFFFF;
    localparam logic [7:0]  MULTI_FN_BIT  = 8'h80;
    localparam logic [7:0]  OFFSET_MASK   = 8'hFC;
    localparam logic [7:0]  CFG_OFF_ID    = 8'h00;
    localparam logic [7:0]  CFG_OFF_CLASS = 8'h08;
    localparam logic [7:0]  CFG_OFF_HDR   = 8'h0C;

    typedef enum logic [1:0] {
        OP_RESTART   = 2'd0,
        OP_ADVANCE   = 2'd1,
        OP_READ_DATA = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_FOUND = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'b0001,
        PH_WAIT_ID    = 4'b0010,
        PH_WAIT_CLASS = 4'b0100,
        PH_WAIT_HDR   = 4'b1000
    } phase_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] read_data;
    } in_item_t;

    // First member sits in the highest bits, so config_address lands at bit 0.
    typedef struct packed {
        logic [7:0]  header_type_out;
        logic [7:0]  prog_if_out;
        logic [7:0]  subclass_out;
        logic [7:0]  class_out;
        logic [15:0] device_id_out;
        logic [15:0] vendor_out;
        logic [2:0]  function_out;
        logic [4:0]  device_out;
        logic [7:0]  bus_out;
        logic [31:0] config_address;
    } out_data_t;

    typedef struct packed {
        kind_t     kind;
        out_data_t data;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/pfe_input_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfe_input_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // read_data
    input  wire logic [1:0]         s_tuser,   // opcode
    input  wire logic               take,
    output logic                    item_valid,
    output pfe_pkg::in_item_t       item
);
    import pfe_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The slot frees in the same cycle its item moves on, so a new transfer
    // can land every cycle while take keeps being asserted.
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode    <= opcode_t'(s_tuser);
            item_reg.read_data <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/pfe_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfe_walker #(
    parameter int BUS_COUNT      = 256,
    parameter int DEVICE_COUNT   = 32,
    parameter int FUNCTION_COUNT = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_valid,
    input  wire pfe_pkg::in_item_t  item,
    output logic                    res_valid,
    output pfe_pkg::result_t        res
);
    import pfe_pkg::*;

    localparam logic [BUS_POS_W-1:0] BUS_END = BUS_POS_W'(BUS_COUNT);
    localparam logic [DEV_POS_W-1:0] DEV_END = DEV_POS_W'(DEVICE_COUNT);
    localparam logic [FN_POS_W-1:0]  FN_END  = FN_POS_W'(FUNCTION_COUNT);

    logic [BUS_POS_W-1:0] bus_pos_reg,  bus_pos_next;
    logic [DEV_POS_W-1:0] dev_pos_reg,  dev_pos_next;
    logic [FN_POS_W-1:0]  fn_pos_reg,   fn_pos_next;
    phase_t               phase_reg,    phase_next;
    logic [15:0]          held_vendor_reg,      held_vendor_next;
    logic [15:0]          held_device_id_reg,   held_device_id_next;
    logic [23:0]          held_class_bytes_reg, held_class_bytes_next;
    logic [7:0]           held_header_type_reg, held_header_type_next;

    logic                 at_end;
    logic                 multi;
    logic                 do_advance;
    logic [BUS_POS_W-1:0] mv_bus;
    logic [DEV_POS_W-1:0] mv_dev;
    logic [FN_POS_W-1:0]  mv_fn;
    logic                 mv_at_end;
    logic [7:0]           read_offset;

    assign at_end = (bus_pos_reg >= BUS_END) && (dev_pos_reg >= DEV_END) &&
                    (fn_pos_reg >= FN_END);

    // Only an advance command can stay within a multifunction device; a
    // skip after an absent vendor always goes to the next device.
    assign multi = (item.opcode == OP_ADVANCE) && (held_vendor_reg != NO_VENDOR) &&
                   ((held_header_type_reg & MULTI_FN_BIT) != 8'h00);

    always_comb begin
        mv_bus = bus_pos_reg;
        mv_dev = dev_pos_reg;
        mv_fn  = fn_pos_reg + FN_POS_W'(1);
        if (at_end) begin
            mv_bus = '0;
            mv_dev = '0;
            mv_fn  = '0;
        end else if ((mv_fn >= FN_END) || !multi) begin
            mv_fn  = '0;
            mv_dev = dev_pos_reg + DEV_POS_W'(1);
            if (mv_dev >= DEV_END) begin
                mv_dev = '0;
                mv_bus = bus_pos_reg + BUS_POS_W'(1);
                if (mv_bus >= BUS_END) begin
                    mv_fn  = FN_END;
                    mv_dev = DEV_END;
                end
            end
        end
        mv_at_end = (mv_bus >= BUS_END) && (mv_dev >= DEV_END) && (mv_fn >= FN_END);
    end

    always_comb begin
        bus_pos_next          = bus_pos_reg;
        dev_pos_next          = dev_pos_reg;
        fn_pos_next           = fn_pos_reg;
        phase_next            = phase_reg;
        held_vendor_next      = held_vendor_reg;
        held_device_id_next   = held_device_id_reg;
        held_class_bytes_next = held_class_bytes_reg;
        held_header_type_next = held_header_type_reg;
        do_advance            = 1'b0;
        res_valid             = 1'b0;
        read_offset           = CFG_OFF_ID;
        res                   = '0;

        if (step_valid) begin
            case (item.opcode)
                OP_RESTART: begin
                    bus_pos_next          = BUS_END;
                    dev_pos_next          = DEV_END;
                    fn_pos_next           = FN_END;
                    phase_next            = PH_IDLE;
                    held_vendor_next      = NO_VENDOR;
                    held_device_id_next   = '0;
                    held_class_bytes_next = '0;
                    held_header_type_next = '0;
                end
                OP_ADVANCE: begin
                    do_advance = (phase_reg == PH_IDLE);
                end
                OP_READ_DATA: begin
                    unique case (phase_reg)
                        PH_WAIT_ID: begin
                            held_vendor_next      = item.read_data[15:0];
                            held_device_id_next   = '0;
                            held_class_bytes_next = '0;
                            held_header_type_next = '0;
                            if (item.read_data[15:0] == NO_VENDOR) begin
                                do_advance = 1'b1;
                            end else begin
                                held_device_id_next = item.read_data[31:16];
                                phase_next          = PH_WAIT_CLASS;
                                res_valid           = 1'b1;
                                res.kind            = KIND_READ;
                                read_offset         = CFG_OFF_CLASS;
                            end
                        end
                        PH_WAIT_CLASS: begin
                            held_class_bytes_next = item.read_data[31:8];
                            phase_next            = PH_WAIT_HDR;
                            res_valid             = 1'b1;
                            res.kind              = KIND_READ;
                            read_offset           = CFG_OFF_HDR;
                        end
                        PH_WAIT_HDR: begin
                            held_header_type_next = item.read_data[23:16];
                            phase_next            = PH_IDLE;
                            res_valid             = 1'b1;
                            res.kind              = KIND_FOUND;
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase

            if (do_advance) begin
                bus_pos_next = mv_bus;
                dev_pos_next = mv_dev;
                fn_pos_next  = mv_fn;
                res_valid    = 1'b1;
                read_offset  = CFG_OFF_ID;
                if (mv_at_end) begin
                    held_vendor_next = NO_VENDOR;
                    phase_next       = PH_IDLE;
                    res.kind         = KIND_DONE;
                end else begin
                    phase_next = PH_WAIT_ID;
                    res.kind   = KIND_READ;
                end
            end

            // The result reports the position as it stands after this step.
            res.data.bus_out      = bus_pos_next[7:0];
            res.data.device_out   = dev_pos_next[4:0];
            res.data.function_out = fn_pos_next[2:0];
            unique case (res.kind)
                KIND_READ: begin
                    res.data.config_address = {1'b1, 7'b0, bus_pos_next[7:0],
                                               dev_pos_next[4:0], fn_pos_next[2:0],
                                               read_offset & OFFSET_MASK};
                end
                KIND_FOUND: begin
                    res.data.vendor_out      = held_vendor_next;
                    res.data.device_id_out   = held_device_id_next;
                    res.data.class_out       = held_class_bytes_next[23:16];
                    res.data.subclass_out    = held_class_bytes_next[15:8];
                    res.data.prog_if_out     = held_class_bytes_next[7:0];
                    res.data.header_type_out = held_header_type_next;
                end
                KIND_DONE: begin
                    res.data.vendor_out = NO_VENDOR;
                end
                default: begin
                    res.data.config_address = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_pos_reg          <= BUS_END;
            dev_pos_reg          <= DEV_END;
            fn_pos_reg           <= FN_END;
            phase_reg            <= PH_IDLE;
            held_vendor_reg      <= NO_VENDOR;
            held_device_id_reg   <= '0;
            held_class_bytes_reg <= '0;
            held_header_type_reg <= '0;
        end else begin
            bus_pos_reg          <= bus_pos_next;
            dev_pos_reg          <= dev_pos_next;
            fn_pos_reg           <= fn_pos_next;
            phase_reg            <= phase_next;
            held_vendor_reg      <= held_vendor_next;
            held_device_id_reg   <= held_device_id_next;
            held_class_bytes_reg <= held_class_bytes_next;
            held_header_type_reg <= held_header_type_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (bus_pos_reg <= BUS_END) && (dev_pos_reg <= DEV_END) && (fn_pos_reg <= FN_END))
        else $error("walk position beyond its end sentinel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        at_end |-> (phase_reg == PH_IDLE))
        else $error("read pending while parked at the end sentinel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && res_valid && (res.kind == KIND_DONE)) |=>
        (held_vendor_reg == NO_VENDOR) && at_end)
        else $error("done reported without parking at the sentinel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && res_valid && (res.kind == KIND_FOUND)) |=> (phase_reg == PH_IDLE))
        else $error("function reported while a read is still pending");

endmodule

`default_nettype wire

// ===== rtl/pfe_result_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfe_result_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire pfe_pkg::result_t   res,
    output logic                    slot_free,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [111:0]            m_tdata,   // config_address, bus_out, device_out,
                                               // function_out, vendor_out, device_id_out,
                                               // class_out, subclass_out, prog_if_out,
                                               // header_type_out
    output logic [1:0]              m_tuser    // kind
);
    import pfe_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A result leaving this cycle makes room for the next one at once.
    assign slot_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data;
    assign m_tuser  = res_reg.kind;

endmodule

`default_nettype wire

// ===== rtl/pci_function_enumerator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A command or read response is held in the input register; any result it produces
// is then loaded into the result register and shown on m_tvalid. Throughput: one
// transfer per cycle on each side while m_tready stays high; the walk position
// updates in one pass of compare-and-increment logic between the two registers.
// Reset (aresetn low, synchronous): both registers empty, the position parked at
// the end sentinel, no read pending, held vendor marked absent.
module pci_function_enumerator #(
    parameter int BUS_COUNT      = 256,
    parameter int DEVICE_COUNT   = 32,
    parameter int FUNCTION_COUNT = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // read_data
    input  wire logic [1:0]    s_tuser,   // opcode
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [111:0]       m_tdata,   // config_address [31:0], bus_out [39:32],
                                          // device_out [44:40], function_out [47:45],
                                          // vendor_out [63:48], device_id_out [79:64],
                                          // class_out [87:80], subclass_out [95:88],
                                          // prog_if_out [103:96], header_type_out [111:104]
    output logic [1:0]         m_tuser    // kind
);
    import pfe_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     slot_free;
    logic     take;
    logic     res_valid;
    result_t  res;

    // An item is processed only when the result register can take whatever it
    // produces.
    assign take = item_valid && slot_free;

    pfe_input_reg u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pfe_walker #(
        .BUS_COUNT      (BUS_COUNT),
        .DEVICE_COUNT   (DEVICE_COUNT),
        .FUNCTION_COUNT (FUNCTION_COUNT)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (take),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res)
    );

    pfe_result_reg u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take && res_valid),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
